>>> hw/rtl/qet_pkg.sv
// Package for the quote/escape tokenizer: payload structs, result kinds,
// register indexes and sizing constants. No dependencies.
package qet_pkg;

  // Default and maximum number of bytes in each character set
  localparam int unsigned SET_BYTES   = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned COUNT_W     = 4;
  // Result groups held between the tokenizer step and the output port
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_DELIM = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DROP_CHARS  = 3'd0,
    REG_DROP_COUNT  = 3'd1,
    REG_KEEP_CHARS  = 3'd2,
    REG_KEEP_COUNT  = 3'd3,
    REG_QUOTE_CHARS = 3'd4,
    REG_QUOTE_COUNT = 3'd5,
    REG_ESC_CHARS   = 3'd6,
    REG_ESC_COUNT   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One result without its last flag
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
  } result_t;

  // All results caused by one input: one or two of them
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } group_t;

  typedef struct packed {
    logic       in_quote;
    logic [7:0] open_quote_byte;
    logic       token_open;
    logic       escape_pending;
  } tok_state_t;

endpackage

>>> hw/rtl/qet_step.sv
// Combinational tokenizer step: set compares, state update and the
// results of one input byte. Depends on qet_pkg.
module qet_step #(
  parameter int unsigned SetBytes = qet_pkg::SET_BYTES
) (
  input  qet_pkg::in_item_t                item_i,
  input  qet_pkg::tok_state_t              state_i,
  input  logic [SetBytes-1:0][7:0]         drop_chars_i,
  input  logic [qet_pkg::COUNT_W-1:0]      drop_count_i,
  input  logic [SetBytes-1:0][7:0]         keep_chars_i,
  input  logic [qet_pkg::COUNT_W-1:0]      keep_count_i,
  input  logic [SetBytes-1:0][7:0]         quote_chars_i,
  input  logic [qet_pkg::COUNT_W-1:0]      quote_count_i,
  input  logic [SetBytes-1:0][7:0]         esc_chars_i,
  input  logic [qet_pkg::COUNT_W-1:0]      esc_count_i,
  output qet_pkg::tok_state_t              state_o,
  output logic                             any_o,
  output qet_pkg::group_t                  group_o
);

  logic [SetBytes-1:0] drop_hit, keep_hit, quote_hit, esc_hit;

  // Parallel compares; an entry counts only below the set's count
  for (genvar i = 0; i < SetBytes; i++) begin : g_cmp
    localparam logic [qet_pkg::COUNT_W-1:0] Pos = qet_pkg::COUNT_W'(i);
    assign drop_hit[i]  = (drop_count_i  > Pos) && (drop_chars_i[i]  == item_i.in_byte);
    assign keep_hit[i]  = (keep_count_i  > Pos) && (keep_chars_i[i]  == item_i.in_byte);
    assign quote_hit[i] = (quote_count_i > Pos) && (quote_chars_i[i] == item_i.in_byte);
    assign esc_hit[i]   = (esc_count_i   > Pos) && (esc_chars_i[i]   == item_i.in_byte);
  end

  logic            is_drop, is_keep, is_quote, is_esc;
  logic            add;
  logic [1:0]      n;
  qet_pkg::result_t res0, res1;

  assign is_drop  = |drop_hit;
  assign is_keep  = |keep_hit;
  assign is_quote = |quote_hit;
  assign is_esc   = |esc_hit;

  always_comb begin
    state_o = state_i;
    add     = 1'b0;
    n       = 2'd0;
    res0    = '{kind: qet_pkg::KIND_BYTE, out_byte: 8'h00};
    res1    = '{kind: qet_pkg::KIND_BYTE, out_byte: 8'h00};

    priority if (state_i.escape_pending) begin
      // literal byte after an escape
      state_o.escape_pending = 1'b0;
      state_o.token_open     = 1'b1;
      res0 = '{kind: qet_pkg::KIND_BYTE, out_byte: item_i.in_byte};
      n    = 2'd1;
    end else if (is_esc) begin
      // escape on the final byte is dropped
      state_o.escape_pending = !item_i.end_of_string;
    end else begin
      add = 1'b1;
      if (is_quote) begin
        if (!state_i.in_quote) begin
          state_o.in_quote        = 1'b1;
          state_o.open_quote_byte = item_i.in_byte;
          add = 1'b0;
        end else if (state_i.open_quote_byte == item_i.in_byte) begin
          state_o.in_quote        = 1'b0;
          state_o.open_quote_byte = 8'h00;
          add = 1'b0;
        end
      end
      // delimiters see the quote state after the update above
      if (!state_o.in_quote && (is_drop || is_keep)) begin
        add = 1'b0;
        if (state_i.token_open) begin
          res0 = '{kind: qet_pkg::KIND_END, out_byte: 8'h00};
          n    = 2'd1;
          state_o.token_open = 1'b0;
        end
        if (is_keep) begin
          if (n == 2'd0) begin
            res0 = '{kind: qet_pkg::KIND_DELIM, out_byte: item_i.in_byte};
          end else begin
            res1 = '{kind: qet_pkg::KIND_DELIM, out_byte: item_i.in_byte};
          end
          n = n + 2'd1;
        end
      end
      if (add) begin
        res0 = '{kind: qet_pkg::KIND_BYTE, out_byte: item_i.in_byte};
        n    = 2'd1;
        state_o.token_open = 1'b1;
      end
    end

    // end of string closes an open token and clears all state
    if (item_i.end_of_string) begin
      if (state_o.token_open) begin
        if (n == 2'd0) begin
          res0 = '{kind: qet_pkg::KIND_END, out_byte: 8'h00};
        end else begin
          res1 = '{kind: qet_pkg::KIND_END, out_byte: 8'h00};
        end
        n = n + 2'd1;
      end
      state_o = '0;
    end
  end

  assign any_o      = (n != 2'd0);
  assign group_o.two = (n == 2'd2);
  assign group_o.r0 = res0;
  assign group_o.r1 = res1;

endmodule

>>> hw/rtl/qet_result_queue.sv
// Result queue: holds the result groups of accepted bytes and sends them
// out one result per transfer. Depends on qet_pkg.
module qet_result_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  qet_pkg::group_t    group_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qet_pkg::out_item_t out_data_o
);

  localparam int unsigned Depth = qet_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  qet_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            sub_q, sub_d;
  logic            xfer, pop;
  qet_pkg::group_t head;

  assign head        = mem_q[rptr_q];
  assign out_valid_o = (count_q != '0);
  assign full_o      = (count_q == CntW'(Depth));
  assign xfer        = out_valid_o && !out_stall_i;

  // second result of a pair carries last, as does a lone result
  always_comb begin
    out_data_o.kind     = sub_q ? head.r1.kind : head.r0.kind;
    out_data_o.out_byte = sub_q ? head.r1.out_byte : head.r0.out_byte;
    out_data_o.last     = sub_q || !head.two;
  end

  assign pop = xfer && out_data_o.last;

  // pointer and count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    sub_d   = sub_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (xfer) begin
      sub_d = !out_data_o.last;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    unique case ({push_i, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      sub_q   <= 1'b0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      sub_q   <= sub_d;
      count_q <= count_d;
    end
  end

  // group storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= group_i;
    end
  end

endmodule

>>> hw/rtl/quote_escape_tokenizer_core.sv
// Top level of the quote/escape tokenizer: configuration registers, state
// registers, step logic and result queue. Depends on qet_pkg, qet_step,
// qet_result_queue.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o  in_data_i  (in_item_t)
//   out      output     out_valid_o/out_stall_i out_data_o (out_item_t)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One input byte is taken per cycle while in_stall_o is low; its results
// enter the result queue on the transfer and leave it in order. Each result
// needs one output transfer, so a byte with two results needs two. in_stall_o rises
// when the two-entry result queue is full. After reset every set is empty
// and all tokenizer state is clear; stalls on the output never drop or
// repeat a result.
module quote_escape_tokenizer_core #(
  parameter int unsigned SetBytes = qet_pkg::SET_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  qet_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output qet_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [qet_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [qet_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CharsW = SetBytes * 8;

  logic [SetBytes-1:0][7:0]        drop_chars_q, keep_chars_q, quote_chars_q, esc_chars_q;
  logic [qet_pkg::COUNT_W-1:0]     drop_count_q, keep_count_q, quote_count_q, esc_count_q;
  qet_pkg::tok_state_t             state_q, state_d;
  qet_pkg::group_t                 group;
  logic                            any_res, in_xfer, full;

  assign in_stall_o = full;
  assign in_xfer    = in_valid_i && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_chars_q  <= '0;
      drop_count_q  <= '0;
      keep_chars_q  <= '0;
      keep_count_q  <= '0;
      quote_chars_q <= '0;
      quote_count_q <= '0;
      esc_chars_q   <= '0;
      esc_count_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (qet_pkg::reg_idx_e'(cfg_idx_i))
        qet_pkg::REG_DROP_CHARS:  drop_chars_q  <= cfg_wdata_i[CharsW-1:0];
        qet_pkg::REG_DROP_COUNT:  drop_count_q  <= cfg_wdata_i[qet_pkg::COUNT_W-1:0];
        qet_pkg::REG_KEEP_CHARS:  keep_chars_q  <= cfg_wdata_i[CharsW-1:0];
        qet_pkg::REG_KEEP_COUNT:  keep_count_q  <= cfg_wdata_i[qet_pkg::COUNT_W-1:0];
        qet_pkg::REG_QUOTE_CHARS: quote_chars_q <= cfg_wdata_i[CharsW-1:0];
        qet_pkg::REG_QUOTE_COUNT: quote_count_q <= cfg_wdata_i[qet_pkg::COUNT_W-1:0];
        qet_pkg::REG_ESC_CHARS:   esc_chars_q   <= cfg_wdata_i[CharsW-1:0];
        qet_pkg::REG_ESC_COUNT:   esc_count_q   <= cfg_wdata_i[qet_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // tokenizer state advances on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  qet_step #(
    .SetBytes(SetBytes)
  ) u_step (
    .item_i        (in_data_i),
    .state_i       (state_q),
    .drop_chars_i  (drop_chars_q),
    .drop_count_i  (drop_count_q),
    .keep_chars_i  (keep_chars_q),
    .keep_count_i  (keep_count_q),
    .quote_chars_i (quote_chars_q),
    .quote_count_i (quote_count_q),
    .esc_chars_i   (esc_chars_q),
    .esc_count_i   (esc_count_q),
    .state_o       (state_d),
    .any_o         (any_res),
    .group_o       (group)
  );

  qet_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer && any_res),
    .group_i     (group),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/quote_escape_tokenizer_core_tb.sv
// Self-checking testbench for quote_escape_tokenizer_core: directed strings, then
// random strings under several character-set settings and back-pressure patterns.
// Depends on qet_pkg and the quote_escape_tokenizer_core RTL only.
module quote_escape_tokenizer_core_tb;

  localparam int unsigned ITEMS_PER_PHASE = 103;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned MAX_REPORTS     = 10;

  // Character-set schemes for the random phases
  localparam int SCHEME_RANDOM = 0;
  localparam int SCHEME_EMPTY  = 1;
  localparam int SCHEME_OVER   = 2;
  localparam int SCHEME_EDGE   = 3;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  qet_pkg::in_item_t              in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  qet_pkg::out_item_t             out_data_o;
  logic                           cfg_we_i    = 1'b0;
  logic [qet_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [qet_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  quote_escape_tokenizer_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  qet_pkg::in_item_t  pending_bytes_q[$];
  qet_pkg::out_item_t token_expect_q[$];
  logic [63:0]        reg_shadow[8];

  // Tokenizer state as the checker sees it
  logic        st_in_quote;
  logic [7:0]  st_quote_byte;
  logic        st_token_open;
  logic        st_escape_pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  bit          in_taken      = 1'b0;
  bit          out_taken     = 1'b0;
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;

  initial begin
    foreach (reg_shadow[i]) reg_shadow[i] = '0;
    st_in_quote       = 1'b0;
    st_quote_byte     = '0;
    st_token_open     = 1'b0;
    st_escape_pending = 1'b0;
  end

  // Membership test; counts above SET_BYTES saturate
  function automatic bit in_char_set(logic [63:0] chars, logic [63:0] count, logic [7:0] b);
    int unsigned n;
    n = (count[3:0] > qet_pkg::SET_BYTES) ? qet_pkg::SET_BYTES : count[3:0];
    for (int unsigned i = 0; i < n; i++) begin
      if (chars[8*i +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the token results of one accepted byte and queue them
  task automatic predict_tokens(qet_pkg::in_item_t item);
    qet_pkg::out_item_t grp[$];
    qet_pkg::out_item_t r;
    logic [7:0] b;
    bit add, drop, keep;
    b = item.in_byte;
    if (st_escape_pending) begin
      st_escape_pending = 1'b0;
      r = '{kind: qet_pkg::KIND_BYTE, out_byte: b, last: 1'b0};
      grp = {grp, r};
      st_token_open = 1'b1;
    end else if (in_char_set(reg_shadow[qet_pkg::REG_ESC_CHARS],
                             reg_shadow[qet_pkg::REG_ESC_COUNT], b)) begin
      if (!item.end_of_string) st_escape_pending = 1'b1;
    end else begin
      add = 1'b1;
      if (in_char_set(reg_shadow[qet_pkg::REG_QUOTE_CHARS],
                      reg_shadow[qet_pkg::REG_QUOTE_COUNT], b)) begin
        if (!st_in_quote) begin
          st_in_quote   = 1'b1;
          st_quote_byte = b;
          add           = 1'b0;
        end else if (st_quote_byte == b) begin
          st_in_quote   = 1'b0;
          st_quote_byte = '0;
          add           = 1'b0;
        end
      end
      // Delimiters only count outside quotes, after the quote update
      if (!st_in_quote) begin
        drop = in_char_set(reg_shadow[qet_pkg::REG_DROP_CHARS],
                           reg_shadow[qet_pkg::REG_DROP_COUNT], b);
        keep = in_char_set(reg_shadow[qet_pkg::REG_KEEP_CHARS],
                           reg_shadow[qet_pkg::REG_KEEP_COUNT], b);
        if (drop || keep) begin
          add = 1'b0;
          if (st_token_open) begin
            r = '{kind: qet_pkg::KIND_END, out_byte: 8'h00, last: 1'b0};
            grp = {grp, r};
            st_token_open = 1'b0;
          end
          if (keep) begin
            r = '{kind: qet_pkg::KIND_DELIM, out_byte: b, last: 1'b0};
            grp = {grp, r};
          end
        end
      end
      if (add) begin
        r = '{kind: qet_pkg::KIND_BYTE, out_byte: b, last: 1'b0};
        grp = {grp, r};
        st_token_open = 1'b1;
      end
    end
    // End of string closes any open token and clears everything
    if (item.end_of_string) begin
      if (st_token_open) begin
        r = '{kind: qet_pkg::KIND_END, out_byte: 8'h00, last: 1'b0};
        grp = {grp, r};
      end
      st_token_open     = 1'b0;
      st_in_quote       = 1'b0;
      st_quote_byte     = '0;
      st_escape_pending = 1'b0;
    end
    if (grp.size() > 0) grp[grp.size()-1].last = 1'b1;
    foreach (grp[i]) token_expect_q = {token_expect_q, grp[i]};
  endtask

  // Rising edge: record transfers, predict, check results, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  = in_valid_i && !in_stall_o;
      out_taken = out_valid_o && !out_stall_i;
      if (in_taken) predict_tokens(in_data_i);
      if (out_taken) begin
        if (token_expect_q.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("ERROR: unexpected result kind=%0d byte=%h last=%b",
                     out_data_o.kind, out_data_o.out_byte, out_data_o.last);
          error_count++;
        end else begin
          qet_pkg::out_item_t exp_r;
          exp_r = token_expect_q.pop_front();
          if (out_data_o.kind !== exp_r.kind || out_data_o.out_byte !== exp_r.out_byte ||
              out_data_o.last !== exp_r.last) begin
            if (error_count < MAX_REPORTS)
              $display("ERROR: expected kind=%0d byte=%h last=%b, got kind=%0d byte=%h last=%b",
                       exp_r.kind, exp_r.out_byte, exp_r.last,
                       out_data_o.kind, out_data_o.out_byte, out_data_o.last);
            error_count++;
          end
        end
      end
      if (in_taken || out_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Byte driver: falling edge, holds the payload until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_bytes_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result-side stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(qet_pkg::reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    reg_shadow[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_sets(logic [63:0] drop_c, logic [63:0] drop_n,
                           logic [63:0] keep_c, logic [63:0] keep_n,
                           logic [63:0] quote_c, logic [63:0] quote_n,
                           logic [63:0] esc_c, logic [63:0] esc_n);
    write_reg(qet_pkg::REG_DROP_CHARS, drop_c);
    write_reg(qet_pkg::REG_DROP_COUNT, drop_n);
    write_reg(qet_pkg::REG_KEEP_CHARS, keep_c);
    write_reg(qet_pkg::REG_KEEP_COUNT, keep_n);
    write_reg(qet_pkg::REG_QUOTE_CHARS, quote_c);
    write_reg(qet_pkg::REG_QUOTE_COUNT, quote_n);
    write_reg(qet_pkg::REG_ESC_CHARS, esc_c);
    write_reg(qet_pkg::REG_ESC_COUNT, esc_n);
  endtask

  function automatic logic [63:0] pack_chars(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic void queue_string(string s);
    qet_pkg::in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.in_byte       = s[i];
      it.end_of_string = (i == s.len() - 1);
      pending_bytes_q  = {pending_bytes_q, it};
    end
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic eos);
    qet_pkg::in_item_t it;
    it.in_byte       = b;
    it.end_of_string = eos;
    pending_bytes_q  = {pending_bytes_q, it};
  endfunction

  // Mostly punctuation, so the four sets overlap often
  function automatic logic [7:0] pool_byte();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 16) return 8'h20 + r[7:0];
    if (r == 16) return 8'h00;
    if (r == 17) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Count register value: chosen low nibble, random upper bits
  function automatic logic [63:0] count_word(logic [3:0] nib);
    logic [63:0] w;
    w      = {$urandom, $urandom};
    w[3:0] = nib;
    return w;
  endfunction

  task automatic random_sets(int scheme);
    logic [63:0] chars[4];
    logic [63:0] cnt[4];
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 8; j++) chars[k][8*j +: 8] = pool_byte();
      case (scheme)
        SCHEME_EMPTY: begin
          cnt[k] = count_word(4'd0);
        end
        SCHEME_OVER: begin
          cnt[k] = count_word(4'($urandom_range(15, 8)));
        end
        SCHEME_EDGE: begin
          chars[k] = (k % 2 == 0) ? 64'h0 : '1;
          cnt[k]   = count_word((k < 2) ? 4'd1 : 4'd8);
        end
        default: begin
          // Keep escapes rare so strings stay readable
          cnt[k] = count_word(4'($urandom_range((k == 3) ? 2 : 15)));
        end
      endcase
    end
    load_sets(chars[0], cnt[0], chars[1], cnt[1], chars[2], cnt[2], chars[3], cnt[3]);
  endtask

  // Byte for random strings: set members, plain letters, or noise
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return reg_shadow[2 * $urandom_range(3)][8 * $urandom_range(7) +: 8];
    if (r < 90) return 8'h61 + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // Wait until everything sent has been checked, then let the pipe settle
  task automatic drain();
    while (pending_bytes_q.size() > 0 || in_valid_i || token_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pushed;
    int unsigned len;
    int          scheme;
    bit          eos_on;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings covering quotes, escapes and both delimiter kinds
    load_sets(pack_chars(" ,"), 64'hA5A5_0000_0000_0002,
              pack_chars(",;|"), 64'd3,
              pack_chars("\"'|^"), 64'd4,
              pack_chars("\\^"), 64'd2);
    queue_string("a ,b;|c d|e\\");
    queue_string("'x\"^y");
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_string(";");
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 6;
        recv_idle_pct = 78;
      end else if (p < 7) begin
        send_idle_pct = 78;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        1:       scheme = SCHEME_EMPTY;
        2:       scheme = SCHEME_OVER;
        3, 8:    scheme = SCHEME_EDGE;
        default: scheme = SCHEME_RANDOM;
      endcase
      random_sets(scheme);
      // Long receiver hold-off while the sender keeps offering bytes
      if (p == 7) hold_req = 1'b1;
      pushed = 0;
      while (pushed < ITEMS_PER_PHASE) begin
        len    = $urandom_range(16, 1);
        eos_on = ($urandom_range(9) != 0);
        for (int i = 0; i < len; i++)
          queue_byte(pick_byte(), eos_on && (i == len - 1));
        pushed += len;
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0 && token_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/qet_pkg.sv
hw/rtl/qet_step.sv
hw/rtl/qet_result_queue.sv
hw/rtl/quote_escape_tokenizer_core.sv
tb/quote_escape_tokenizer_core_tb.sv
